// ----- design/glyph_text_rasterizer_top_macros.svh -----
// ---------------------------------------------------------------------------
// Glyph text rasterizer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef GLYPH_TEXT_RASTERIZER_TOP_MACROS_SVH
`define GLYPH_TEXT_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication
`define GTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gtr_pkg.sv -----
// ---------------------------------------------------------------------------
// Glyph text rasterizer package
// Font constants, glyph ROM, register indexes and controller/datapath links.
// ---------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

  // Font geometry
  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 5;
  localparam int GAP_WIDTH    = 1;
  localparam int GLYPH_CELLS  = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int PITCH        = GLYPH_WIDTH + GAP_WIDTH;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_ALIGN_MODE  = 3'd2;
  localparam logic [2:0] REG_CELL_SCALE  = 3'd3;
  localparam logic [2:0] REG_TEXT_LENGTH = 3'd4;

  // Alignment codes
  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  // Character codes bounding the font
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [5:0] LETTER_BASE = 6'd10;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } glyph_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic calc_width;
    logic place_pen;
    logic set_stop;
    logic load_glyph;
    logic step_cell;
    logic emit;
    logic advance_pen;
  } gtr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_flag;
    logic stopped;
    logic glyph_ok;
    logic cell_lit;
    logic rest_zero;
    logic out_free;
  } gtr_stat_t;

  // Map a character byte onto a ROM index
  function automatic glyph_sel_t char_to_glyph(input logic [7:0] code);
    glyph_sel_t sel;
    logic [7:0] diff;
    sel = '0;
    diff = '0;
    if (code >= CHAR_0 && code <= CHAR_9) begin
      diff = code - CHAR_0;
      sel.ok = 1'b1;
      sel.idx = diff[5:0];
    end else if (code >= CHAR_A && code <= CHAR_Z) begin
      diff = code - CHAR_A;
      sel.ok = 1'b1;
      sel.idx = diff[5:0] + LETTER_BASE;
    end
    return sel;
  endfunction

  // Cell mask of a glyph: bit i is cell i in row-major order
  function automatic logic [GLYPH_CELLS-1:0] glyph_mask(input logic [5:0] idx);
    logic [GLYPH_CELLS-1:0] rows;
    logic [GLYPH_CELLS-1:0] mask;
    // rows holds row 0 in the top five bits, leftmost column highest
    case (idx)
      6'd0:  rows = {5'h0E, 5'h13, 5'h15, 5'h19, 5'h0E};
      6'd1:  rows = {5'h04, 5'h1C, 5'h04, 5'h04, 5'h1F};
      6'd2:  rows = {5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F};
      6'd3:  rows = {5'h1E, 5'h01, 5'h06, 5'h01, 5'h1E};
      6'd4:  rows = {5'h02, 5'h06, 5'h1A, 5'h1F, 5'h02};
      6'd5:  rows = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E};
      6'd6:  rows = {5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E};
      6'd7:  rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
      6'd8:  rows = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
      6'd9:  rows = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
      6'd10: rows = {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11};
      6'd11: rows = {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E};
      6'd12: rows = {5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E};
      6'd13: rows = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      6'd14: rows = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F};
      6'd15: rows = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10};
      6'd16: rows = {5'h0E, 5'h10, 5'h13, 5'h11, 5'h0E};
      6'd17: rows = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      6'd18: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F};
      6'd19: rows = {5'h0F, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd20: rows = {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11};
      6'd21: rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd22: rows = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11};
      6'd23: rows = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
      6'd24: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd25: rows = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
      6'd26: rows = {5'h0E, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd27: rows = {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11};
      6'd28: rows = {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
      6'd29: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd30: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd31: rows = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd32: rows = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
      6'd33: rows = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      6'd34: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04};
      6'd35: rows = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      default: rows = '0;
    endcase
    // cell 0 is the top-left pixel, i.e. the highest bit of rows
    for (int i = 0; i < GLYPH_CELLS; i++) begin
      mask[i] = rows[GLYPH_CELLS-1-i];
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

// ----- design/gtr_ctrl.sv -----
// ---------------------------------------------------------------------------
// Glyph text rasterizer controller
// Sequences pen placement, character check, cell walk and pen advance.
// ---------------------------------------------------------------------------
`default_nettype none

module gtr_ctrl
  import gtr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire gtr_stat_t stat,
  output gtr_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WIDTH   = 3'd1;
  localparam logic [2:0] ST_PLACE   = 3'd2;
  localparam logic [2:0] ST_CHECK   = 3'd3;
  localparam logic [2:0] ST_WALK    = 3'd4;
  localparam logic [2:0] ST_ADVANCE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_axis_tready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load_item = 1'b1;
          state_next = stat.start_flag ? ST_WIDTH : ST_CHECK;
        end
      end
      ST_WIDTH: begin
        cmd.calc_width = 1'b1;
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        cmd.place_pen = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.stopped) begin
          state_next = ST_IDLE;
        end else if (!stat.glyph_ok) begin
          cmd.set_stop = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.load_glyph = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // dark cells pass at once; lit cells wait for the output register
        if (!stat.cell_lit) begin
          cmd.step_cell = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.step_cell = 1'b1;
          if (stat.rest_zero) begin
            state_next = ST_ADVANCE;
          end
        end
      end
      ST_ADVANCE: begin
        cmd.advance_pen = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/gtr_datapath.sv -----
// ---------------------------------------------------------------------------
// Glyph text rasterizer datapath
// Configuration registers, pen arithmetic, glyph cell walker, output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "glyph_text_rasterizer_top_macros.svh"

module gtr_datapath
  import gtr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire gtr_cmd_t    cmd,
  output gtr_stat_t        stat
);

  localparam logic [2:0] LAST_COL = 3'(GLYPH_WIDTH - 1);

  // Configuration
  logic [12:0] origin_x;
  logic [12:0] origin_y;
  logic [1:0]  align_mode;
  logic [4:0]  cell_scale;
  logic [7:0]  text_length;

  // Working state
  logic [7:0]             char_code;
  logic [17:0]            pen_x_half;
  logic                   string_stopped;
  logic [16:0]            width_px;
  logic [GLYPH_CELLS-1:0] mask;
  logic [2:0]             col;
  logic [8:0]             col_off;
  logic [15:0]            y_acc;

  // Output register
  logic [15:0] out_x;
  logic [15:0] out_y;

  glyph_sel_t  sel;
  logic [11:0] span_cols;
  logic [16:0] width_prod;
  logic [17:0] ox2;
  logic [17:0] pen_place;
  logic [9:0]  step_half;
  logic [7:0]  glyph_h_px;
  logic [15:0] top_y;
  logic [18:0] xh;
  logic [18:0] x_trunc;
  logic        rest_zero;

  assign sel       = char_to_glyph(char_code);
  assign rest_zero = (mask[GLYPH_CELLS-1:1] == '0);

  // Text width in pixels: scale * (len*pitch - gap)
  assign span_cols  = 12'(text_length) * 12'(PITCH) - 12'(GAP_WIDTH);
  assign width_prod = 17'(span_cols) * 17'(cell_scale);

  // Pen placement in half pixels
  assign ox2 = {{4{origin_x[12]}}, origin_x, 1'b0};
  always_comb begin
    case (align_mode)
      ALIGN_LEFT:   pen_place = ox2;
      ALIGN_CENTER: pen_place = ox2 - {1'b0, width_px};
      ALIGN_RIGHT:  pen_place = ox2 - {width_px, 1'b0};
      default:      pen_place = '0;
    endcase
  end

  // Pen advance per glyph and top edge of the glyph
  assign step_half  = 10'(cell_scale) * 10'(2 * PITCH);
  assign glyph_h_px = 8'(cell_scale) * 8'(GLYPH_HEIGHT);
  assign top_y      = {{3{origin_y[12]}}, origin_y} - {9'b0, glyph_h_px[7:1]};

  // Left edge: half-pixel sum halved, rounded toward zero
  assign xh      = {pen_x_half[17], pen_x_half} + {10'b0, col_off};
  assign x_trunc = {xh[18], xh[18:1]} + {18'b0, xh[18] & xh[0]};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      align_mode  <= ALIGN_LEFT;
      cell_scale  <= 5'd1;
      text_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin_x    <= cfg_data;
        REG_ORIGIN_Y:    origin_y    <= cfg_data;
        REG_ALIGN_MODE:  align_mode  <= cfg_data[1:0];
        REG_CELL_SCALE:  cell_scale  <= cfg_data[4:0];
        REG_TEXT_LENGTH: text_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pen and stop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x_half     <= '0;
      string_stopped <= 1'b0;
    end else begin
      if (cmd.place_pen) begin
        pen_x_half     <= pen_place;
        string_stopped <= 1'b0;
      end
      if (cmd.set_stop) begin
        string_stopped <= 1'b1;
      end
      if (cmd.advance_pen) begin
        pen_x_half <= pen_x_half + {8'b0, step_half};
      end
    end
  end

  // Item capture and width
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      char_code <= s_axis_tdata;
    end
    if (cmd.calc_width) begin
      width_px <= (text_length == '0) ? '0 : width_prod;
    end
  end

  // Cell walker
  always_ff @(posedge clk) begin
    if (cmd.load_glyph) begin
      mask    <= glyph_mask(sel.idx);
      col     <= '0;
      col_off <= '0;
      y_acc   <= top_y;
    end else if (cmd.step_cell) begin
      mask <= {1'b0, mask[GLYPH_CELLS-1:1]};
      if (col == LAST_COL) begin
        col     <= '0;
        col_off <= '0;
        y_acc   <= y_acc + 16'(cell_scale);
      end else begin
        col     <= col + 3'd1;
        col_off <= col_off + {3'b0, cell_scale, 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x        <= x_trunc[15:0];
      out_y        <= y_acc;
      m_axis_tlast <= rest_zero;
    end
  end

  assign m_axis_tdata = {out_y, out_x};

  // Status
  always_comb begin
    stat            = '0;
    stat.start_flag = s_axis_tuser;
    stat.stopped    = string_stopped;
    stat.glyph_ok   = sel.ok;
    stat.cell_lit   = mask[0];
    stat.rest_zero  = rest_zero;
    stat.out_free   = !m_axis_tvalid || m_axis_tready;
  end

  // Checks
  `GTR_ASSERT_NOW(a_emit_lit_cell, cmd.emit, mask[0] && (!m_axis_tvalid || m_axis_tready),
    "square emitted from a dark cell or over a waiting result")
  `GTR_ASSERT_NOW(a_glyph_ok, cmd.load_glyph, sel.ok && !string_stopped,
    "glyph loaded for an unsupported character or a stopped string")
  `GTR_ASSERT_NEXT(a_last_mark, cmd.emit, m_axis_tlast == (mask == '0),
    "last mark disagrees with the remaining lit cells")

endmodule

`default_nettype wire

// ----- design/glyph_text_rasterizer_top.sv -----
// ---------------------------------------------------------------------------
// Glyph text rasterizer
// 5x5 bitmap font character generator producing one square per lit cell.
// ---------------------------------------------------------------------------
// One character is taken per input item and turned into filled squares, one
// per lit cell of its glyph, in row-major order with tlast on the last one.
// An item passes the glyph check, a cell walk to its last lit cell and the
// pen advance; a string start first adds the width and place states, which
// set the pen from origin, alignment and text width. A stopped or unsupported
// character returns to idle from the check. The walker visits one cell per
// cycle, holding while the output register waits to be taken. The user must
// write configuration only while the block is idle, which is not enforced.
`default_nettype none

module glyph_text_rasterizer_top
  import gtr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  // character input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tuser,   // string_start
  // square output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] rect_x, [31:16] rect_y
  output logic             m_axis_tlast    // last_cell
);

  gtr_cmd_t  cmd;
  gtr_stat_t stat;

  gtr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  gtr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire
